// ===== rtl/core/msf_pkg.sv =====
// Shared types and constants for the MSF time code receiver.
`timescale 1ns / 1ps

package msf_pkg;

  // Default number of samples that make up one majority decision.
  localparam int unsigned SAMPLES_PER_BIT = 8;
  localparam int unsigned FRAME_BYTES     = 8;
  localparam int unsigned FRAME_BITS      = FRAME_BYTES * 8;
  localparam int unsigned FRAME_IDX_W     = $clog2(FRAME_BITS);
  localparam logic [FRAME_IDX_W-1:0] SECOND_LAST = FRAME_IDX_W'(60);

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MINUTE_MASK    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MINUTE_PATTERN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_MASK    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_PATTERN = 2'd3;

  localparam logic [CFG_DATA_W-1:0] MINUTE_MASK_RST    = 16'h01FE;
  localparam logic [CFG_DATA_W-1:0] MINUTE_PATTERN_RST = 16'h001E;
  localparam logic [CFG_DATA_W-1:0] SECOND_MASK_RST    = 16'h03FC;
  localparam logic [CFG_DATA_W-1:0] SECOND_PATTERN_RST = 16'h0004;

  // History bits that carry the A and B bits of a second.
  localparam int unsigned A_BIT_POS = 6;
  localparam int unsigned B_BIT_POS = 7;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] minute_mask;
    logic [CFG_DATA_W-1:0] minute_pattern;
    logic [CFG_DATA_W-1:0] second_mask;
    logic [CFG_DATA_W-1:0] second_pattern;
  } msf_cfg_t;

  typedef struct packed {
    logic carrier_level;
  } msf_sample_t;

  typedef struct packed {
    logic [7:0] year_value;
    logic [4:0] month_value;
    logic [5:0] day_of_month;
    logic [2:0] day_of_week;
    logic [5:0] hour_value;
    logic [6:0] minute_value;
    logic [2:0] parity_errors;
  } msf_time_t;

  typedef struct packed {
    logic minute_hit;
    logic second_hit;
  } msf_status_t;

endpackage

// ===== rtl/core/msf_stream_if.sv =====
// Valid/ready stream interfaces for receiver samples and decoded time beats.
`timescale 1ns / 1ps

interface msf_sample_if;
  logic                 valid;
  logic                 ready;
  msf_pkg::msf_sample_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface msf_time_if;
  logic               valid;
  logic               ready;
  msf_pkg::msf_time_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/msf_time_code_receiver_top.sv =====
// Top level of the MSF time code receiver: sample register, core, decode, result register.
//
// Usage:
//   sample_i carries one receiver level per beat; result_o carries one decoded
//   time beat per minute marker. Both are valid/ready streams.
//   Every SamplesPerBit samples form one majority decision that is shifted
//   into the marker history; second markers store the A/B bits of the frame,
//   a minute marker decodes the stored frame into one result beat.
//   Throughput: one sample per cycle, except while a sample is held as below.
//   result_o.valid rises once the sample completing the minute marker has
//   passed the sample register and then the result register.
//   Configuration (cfg_we_i, cfg_idx_i, cfg_wdata_i) writes the marker masks
//   and patterns; write only while no sample is in flight.
//   Reset clears the counters, history, second index and A/B stores and loads
//   the default masks and patterns.
//   When result_o stalls, samples keep flowing; only a sample that would
//   produce a second result while the first still waits is held, and
//   sample_i.ready drops until the waiting beat is taken.
`timescale 1ns / 1ps

module msf_time_code_receiver_top #(
  parameter int unsigned SamplesPerBit = msf_pkg::SAMPLES_PER_BIT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  msf_sample_if.sink                       sample_i,
  msf_time_if.source                       result_o,
  input  logic                             cfg_we_i,
  input  logic [msf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [msf_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  msf_pkg::msf_cfg_t    cfg_q;
  msf_pkg::msf_status_t status;
  msf_pkg::msf_time_t   decoded, res_q;
  logic [msf_pkg::FRAME_BITS-1:0] a_store, b_store;
  logic in_valid_q, level_q, res_valid_q, advance;

  // Hold the sample only when its result cannot go into an occupied slot.
  assign advance = in_valid_q &&
      !(status.minute_hit && res_valid_q && !result_o.ready);
  assign sample_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.minute_mask    <= msf_pkg::MINUTE_MASK_RST;
      cfg_q.minute_pattern <= msf_pkg::MINUTE_PATTERN_RST;
      cfg_q.second_mask    <= msf_pkg::SECOND_MASK_RST;
      cfg_q.second_pattern <= msf_pkg::SECOND_PATTERN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        msf_pkg::REG_MINUTE_MASK:    cfg_q.minute_mask    <= cfg_wdata_i;
        msf_pkg::REG_MINUTE_PATTERN: cfg_q.minute_pattern <= cfg_wdata_i;
        msf_pkg::REG_SECOND_MASK:    cfg_q.second_mask    <= cfg_wdata_i;
        msf_pkg::REG_SECOND_PATTERN: cfg_q.second_pattern <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      in_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      level_q <= sample_i.data.carrier_level;
    end
  end

  msf_rx_core #(
    .SamplesPerBit(SamplesPerBit)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .level_i  (level_q),
    .cfg_i    (cfg_q),
    .status_o (status),
    .a_store_o(a_store),
    .b_store_o(b_store)
  );

  msf_decode u_decode (
    .a_i   (a_store),
    .b_i   (b_store),
    .time_o(decoded)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance && status.minute_hit) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && status.minute_hit) begin
      res_q <= decoded;
    end
  end

  assign result_o.valid = res_valid_q;
  assign result_o.data  = res_q;

endmodule

// ===== rtl/core/msf_rx_core.sv =====
// Majority slicer, marker detection and A/B bit frame store.
`timescale 1ns / 1ps

module msf_rx_core #(
  parameter int unsigned SamplesPerBit = msf_pkg::SAMPLES_PER_BIT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          level_i,
  input  msf_pkg::msf_cfg_t             cfg_i,
  output msf_pkg::msf_status_t          status_o,
  output logic [msf_pkg::FRAME_BITS-1:0] a_store_o,
  output logic [msf_pkg::FRAME_BITS-1:0] b_store_o
);

  localparam int unsigned CntW  = $clog2(SamplesPerBit);
  localparam int unsigned HighW = $clog2(SamplesPerBit + 1);
  localparam int unsigned IdxW  = msf_pkg::FRAME_IDX_W;

  logic [CntW-1:0]                 cnt_q;
  logic [HighW-1:0]                high_q, high_sum;
  logic [15:0]                     hist_q, hist_d;
  logic [IdxW-1:0]                 idx_q;
  logic [msf_pkg::FRAME_BITS-1:0]  a_q, b_q;
  logic                            last, decision, minute_hit, second_hit;

  assign last     = (cnt_q == CntW'(SamplesPerBit - 1));
  assign high_sum = high_q + HighW'(level_i);
  assign decision = (high_sum >= HighW'(SamplesPerBit / 2));
  assign hist_d   = {hist_q[14:0], decision};

  // Minute marker wins over second marker.
  assign minute_hit = last &&
      ((hist_d & cfg_i.minute_mask) == cfg_i.minute_pattern);
  assign second_hit = last && !minute_hit &&
      ((hist_d & cfg_i.second_mask) == cfg_i.second_pattern);

  assign status_o.minute_hit = minute_hit;
  assign status_o.second_hit = second_hit;
  assign a_store_o = a_q;
  assign b_store_o = b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      high_q <= '0;
      hist_q <= '0;
      idx_q  <= '0;
      a_q    <= '0;
      b_q    <= '0;
    end else if (step_i) begin
      if (last) begin
        cnt_q  <= '0;
        high_q <= '0;
        hist_q <= hist_d;
      end else begin
        cnt_q  <= cnt_q + CntW'(1);
        high_q <= high_sum;
      end
      if (minute_hit) begin
        idx_q <= '0;
      end else if (second_hit) begin
        a_q[idx_q] <= hist_d[msf_pkg::A_BIT_POS];
        b_q[idx_q] <= hist_d[msf_pkg::B_BIT_POS];
        idx_q <= (idx_q >= msf_pkg::SECOND_LAST) ? '0 : idx_q + IdxW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/msf_decode.sv =====
// BCD field decode and odd-parity checks over the stored frame.
`timescale 1ns / 1ps

module msf_decode (
  input  logic [msf_pkg::FRAME_BITS-1:0] a_i,
  input  logic [msf_pkg::FRAME_BITS-1:0] b_i,
  output msf_pkg::msf_time_t             time_o
);

  logic [3:0] yr_t, yr_u, mo_u, dm_u, hr_u, mi_u;
  logic       mo_t;
  logic [1:0] dm_t, hr_t;
  logic [2:0] mi_t, dow;
  logic [7:0] year_v;
  logic [4:0] month_v;
  logic [5:0] dom_v, hour_v;
  logic [6:0] min_v;
  logic       fail_year, fail_date, fail_dow, fail_time;
  logic [2:0] errs;

  // A bits are sent most significant first.
  assign yr_t = {a_i[17], a_i[18], a_i[19], a_i[20]};
  assign yr_u = {a_i[21], a_i[22], a_i[23], a_i[24]};
  assign mo_t = a_i[25];
  assign mo_u = {a_i[26], a_i[27], a_i[28], a_i[29]};
  assign dm_t = {a_i[30], a_i[31]};
  assign dm_u = {a_i[32], a_i[33], a_i[34], a_i[35]};
  assign dow  = {a_i[36], a_i[37], a_i[38]};
  assign hr_t = {a_i[39], a_i[40]};
  assign hr_u = {a_i[41], a_i[42], a_i[43], a_i[44]};
  assign mi_t = {a_i[45], a_i[46], a_i[47]};
  assign mi_u = {a_i[48], a_i[49], a_i[50], a_i[51]};

  // tens * 10 as shift-and-add
  assign year_v  = {1'b0, yr_t, 3'b0} + {3'b0, yr_t, 1'b0} + {4'b0, yr_u};
  assign month_v = {1'b0, mo_t, 3'b0} + {3'b0, mo_t, 1'b0} + {1'b0, mo_u};
  assign dom_v   = {1'b0, dm_t, 3'b0} + {3'b0, dm_t, 1'b0} + {2'b0, dm_u};
  assign hour_v  = {1'b0, hr_t, 3'b0} + {3'b0, hr_t, 1'b0} + {2'b0, hr_u};
  assign min_v   = {1'b0, mi_t, 3'b0} + {3'b0, mi_t, 1'b0} + {3'b0, mi_u};

  // Odd parity: an even total of ones is a failure.
  assign fail_year = ~(^a_i[24:17] ^ b_i[54]);
  assign fail_date = ~(^a_i[35:25] ^ b_i[55]);
  assign fail_dow  = ~(^a_i[38:36] ^ b_i[56]);
  assign fail_time = ~(^a_i[51:39] ^ b_i[57]);

  // Date and time checks each cover two fields and count twice.
  assign errs = 3'(fail_year) + {1'b0, fail_date, 1'b0} + 3'(fail_dow)
              + {1'b0, fail_time, 1'b0};

  always_comb begin
    time_o.parity_errors = errs;
    if (errs != 3'd0) begin
      time_o.year_value   = '0;
      time_o.month_value  = '0;
      time_o.day_of_month = '0;
      time_o.day_of_week  = '0;
      time_o.hour_value   = '0;
      time_o.minute_value = '0;
    end else begin
      time_o.year_value   = year_v;
      time_o.month_value  = month_v;
      time_o.day_of_month = dom_v;
      time_o.day_of_week  = dow;
      time_o.hour_value   = hour_v;
      time_o.minute_value = min_v;
    end
  end

endmodule

// ===== dv/msf_time_code_receiver_top_tb.sv =====
// Self-checking testbench for the MSF time code receiver: sample stream in, decoded time out.
`timescale 1ns / 1ps

module msf_time_code_receiver_top_tb;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned LONG_GAP   = 20;
  localparam int unsigned DATA_W     = msf_pkg::CFG_DATA_W;
  localparam int unsigned SPB        = msf_pkg::SAMPLES_PER_BIT;

  localparam msf_pkg::msf_cfg_t RESET_CFG = '{msf_pkg::MINUTE_MASK_RST,
      msf_pkg::MINUTE_PATTERN_RST, msf_pkg::SECOND_MASK_RST, msf_pkg::SECOND_PATTERN_RST};
  // Second marker ignores history bits 6 and 7 so that A and B carry data.
  localparam msf_pkg::msf_cfg_t FRAME_CFG = '{msf_pkg::MINUTE_MASK_RST,
      msf_pkg::MINUTE_PATTERN_RST, 16'h003C, 16'h0004};
  // Every decision is a second; minute on four highs followed by four lows.
  localparam msf_pkg::msf_cfg_t DENSE_CFG = '{16'h00FF, 16'h00F0, 16'h0000, 16'h0000};
  // Pattern outside its mask: minute never fires, every decision is a second.
  localparam msf_pkg::msf_cfg_t NO_MINUTE_CFG = '{16'h0000, 16'h0001, 16'h0000, 16'h0000};

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we;
  logic [msf_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [msf_pkg::CFG_DATA_W-1:0] cfg_wdata;

  msf_sample_if smp_if ();
  msf_time_if   res_if ();

  msf_time_code_receiver_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (smp_if),
    .result_o   (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver state as the decoder sees it.
  msf_pkg::msf_cfg_t                rx_cfg     = RESET_CFG;
  int unsigned                      rx_samples = 0;
  int unsigned                      rx_highs   = 0;
  logic [15:0]                      rx_history = '0;
  logic [msf_pkg::FRAME_IDX_W-1:0]  rx_second  = '0;
  logic [msf_pkg::FRAME_BITS-1:0]   rx_a_bits  = '0;
  logic [msf_pkg::FRAME_BITS-1:0]   rx_b_bits  = '0;

  msf_pkg::msf_sample_t level_q[$];
  msf_pkg::msf_time_t   decoded_q[$];
  int unsigned pushed_samples = 0;
  int unsigned mismatches     = 0;
  int unsigned idle_cycles    = 0;
  int unsigned tx_gap;
  int unsigned rx_stall;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  function automatic int unsigned bcd_field(int unsigned first, int unsigned n);
    int unsigned sum;
    int unsigned k;
    sum = 0;
    for (int unsigned j = 0; j < n; j++) begin
      k = n - 1 - j;
      if (rx_a_bits[first + j]) sum += (k < 4) ? (1 << k) : (10 << (k - 4));
    end
    return sum;
  endfunction

  // 1 when A[first..last] plus B[pbit] holds an even number of ones.
  function automatic int unsigned parity_miss(int unsigned first, int unsigned last,
                                              int unsigned pbit);
    int unsigned ones;
    ones = rx_b_bits[pbit];
    for (int unsigned i = first; i <= last; i++) ones += rx_a_bits[i];
    return (ones % 2 == 0) ? 1 : 0;
  endfunction

  function automatic msf_pkg::msf_time_t decode_stored_frame();
    msf_pkg::msf_time_t t;
    int unsigned        errs;
    errs = parity_miss(17, 24, 54) + 2 * parity_miss(25, 35, 55)
         + parity_miss(36, 38, 56) + 2 * parity_miss(39, 51, 57);
    t = '0;
    if (errs == 0) begin
      t.year_value   = 8'(bcd_field(17, 8));
      t.month_value  = 5'(bcd_field(25, 5));
      t.day_of_month = 6'(bcd_field(30, 6));
      t.day_of_week  = 3'(bcd_field(36, 3));
      t.hour_value   = 6'(bcd_field(39, 6));
      t.minute_value = 7'(bcd_field(45, 7));
    end
    t.parity_errors = 3'(errs);
    return t;
  endfunction

  // Advance by one sample; returns 1 when a minute marker yields a decoded time.
  function automatic bit advance_receiver(logic level, output msf_pkg::msf_time_t t);
    logic hi;
    t = '0;
    rx_highs += level;
    rx_samples++;
    if (rx_samples < SPB) return 1'b0;
    hi = (rx_highs >= SPB / 2);
    rx_samples = 0;
    rx_highs   = 0;
    rx_history = {rx_history[14:0], hi};
    if ((rx_history & rx_cfg.minute_mask) == rx_cfg.minute_pattern) begin
      t = decode_stored_frame();
      rx_second = '0;
      return 1'b1;
    end
    if ((rx_history & rx_cfg.second_mask) == rx_cfg.second_pattern) begin
      rx_a_bits[rx_second] = rx_history[msf_pkg::A_BIT_POS];
      rx_b_bits[rx_second] = rx_history[msf_pkg::B_BIT_POS];
      rx_second = (rx_second >= msf_pkg::SECOND_LAST) ? '0 : rx_second + 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void push_sample(logic level);
    msf_pkg::msf_sample_t s;
    s.carrier_level = level;
    level_q.push_back(s);
    pushed_samples++;
  endfunction

  function automatic void push_pattern(logic [SPB-1:0] pat);
    for (int i = 0; i < SPB; i++) push_sample(pat[i]);
  endfunction

  // Random sample placement whose majority lands on the wanted decision.
  function automatic void push_decision(logic v);
    logic [SPB-1:0] pat;
    do begin
      pat = SPB'($urandom);
    end while (($countones(pat) >= SPB / 2) != v);
    push_pattern(pat);
  endfunction

  // Raw samples, then pad back onto a decision boundary.
  function automatic void push_noise(int unsigned n);
    repeat (n) push_sample(1'($urandom_range(0, 1)));
    while (pushed_samples % SPB != 0) push_sample(1'($urandom_range(0, 1)));
  endfunction

  function automatic void push_runs(int unsigned n);
    logic        v;
    int unsigned run;
    while (n > 0) begin
      v   = 1'($urandom_range(0, 1));
      run = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
      while (run > 0 && n > 0) begin
        push_decision(v);
        run--;
        n--;
      end
    end
  endfunction

  // Decisions B, A, 0, 0, 0, 1, 1, 0: one second marker per block, sent msb first.
  function automatic void push_second(logic a, logic b);
    logic [7:0] word;
    word = {b, a, 6'b000110};
    if ($urandom_range(0, 199) == 0) word[$urandom_range(0, 7)] ^= 1'b1;
    for (int i = 7; i >= 0; i--) push_decision(word[i]);
  endfunction

  // Four lows, four highs, then the decision on which the minute fires.
  function automatic void push_minute();
    for (int i = 7; i >= 0; i--) push_decision(1'(i < 4));
    push_decision(1'($urandom_range(0, 1)));
  endfunction

  // Four highs then four lows; the last decision fires the dense minute.
  function automatic void push_dense_minute();
    for (int i = 7; i >= 0; i--) push_decision(1'(i >= 4));
  endfunction

  function automatic logic [msf_pkg::FRAME_BITS-1:0] place_bcd(
      logic [msf_pkg::FRAME_BITS-1:0] a, int unsigned first, int unsigned n, int unsigned v);
    int unsigned code;
    code = ((v / 10) << 4) | (v % 10);
    for (int unsigned j = 0; j < n; j++) a[first + j] = code[n - 1 - j];
    return a;
  endfunction

  // With every decision a second, A[i] is the decision sent i - 5 places after
  // the minute and B[i] equals A[i - 1], so A[53..56] carry the parity bits.
  function automatic void push_dense_frame(bit clean);
    logic [msf_pkg::FRAME_BITS-1:0] a;
    logic [3:0]                     par;
    int unsigned                    pick;
    a    = {$urandom, $urandom};
    pick = clean ? 2 : $urandom_range(0, 7);
    if (pick == 1) begin
      a[51:17] = '1;
    end else if (pick > 1) begin
      a = place_bcd(a, 17, 8, $urandom_range(0, 99));
      a = place_bcd(a, 25, 5, $urandom_range(1, 12));
      a = place_bcd(a, 30, 6, $urandom_range(1, 31));
      a = place_bcd(a, 36, 3, $urandom_range(0, 6));
      a = place_bcd(a, 39, 6, $urandom_range(0, 23));
      a = place_bcd(a, 45, 7, $urandom_range(0, 59));
    end
    par[0] = ~^a[24:17];
    par[1] = ~^a[35:25];
    par[2] = ~^a[38:36];
    par[3] = ~^a[51:39];
    if (!clean && $urandom_range(0, 2) == 0) par ^= 4'($urandom_range(1, 15));
    a[56:53] = par;
    for (int unsigned i = 6; i <= 56; i++) push_decision(a[i]);
    push_dense_minute();
  endfunction

  task automatic wait_drain();
    while (level_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic program_regs(msf_pkg::msf_cfg_t c);
    wait_drain();
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= msf_pkg::REG_MINUTE_MASK;
    cfg_wdata <= c.minute_mask;
    @(posedge clk_i);
    cfg_idx   <= msf_pkg::REG_MINUTE_PATTERN;
    cfg_wdata <= c.minute_pattern;
    @(posedge clk_i);
    cfg_idx   <= msf_pkg::REG_SECOND_MASK;
    cfg_wdata <= c.second_mask;
    @(posedge clk_i);
    cfg_idx   <= msf_pkg::REG_SECOND_PATTERN;
    cfg_wdata <= c.second_pattern;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    rx_cfg = c;
  endtask

  task automatic run_runs(int unsigned n);
    if ($urandom_range(0, 3) == 0) push_noise($urandom_range(1, 30));
    push_runs(n);
  endtask

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, LONG_GAP);
  endfunction

  // Sample driver: the beat on the bus is the head of level_q.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      smp_if.valid <= 1'b0;
      smp_if.data  <= '0;
      tx_gap = 0;
    end else begin
      if (smp_if.valid && smp_if.ready) begin
        void'(level_q.pop_front());
        tx_gap = pick_gap(tx_calm);
        if ($urandom_range(0, 299) == 0) tx_calm = !tx_calm;
      end
      if (tx_gap > 0) begin
        tx_gap--;
        smp_if.valid <= 1'b0;
      end else if (level_q.size() != 0) begin
        smp_if.valid <= 1'b1;
        smp_if.data  <= level_q[0];
      end else begin
        smp_if.valid <= 1'b0;
      end
    end
  end

  // Result sink: hold ready low for random stalls.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      rx_stall = 0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) rx_stall = pick_gap(rx_calm);
      if ($urandom_range(0, 499) == 0) rx_calm = !rx_calm;
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    msf_pkg::msf_time_t t;
    msf_pkg::msf_time_t want;
    bit                 hit;
    if (rst_ni) begin
      idle_cycles++;
      if (smp_if.valid && smp_if.ready) begin
        idle_cycles = 0;
        hit = advance_receiver(smp_if.data.carrier_level, t);
        if (hit) decoded_q.push_back(t);
      end
      if (res_if.valid && res_if.ready) begin
        idle_cycles = 0;
        if (decoded_q.size() == 0) begin
          $error("result beat with no decoded time pending");
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          check_field("year_value", want.year_value, res_if.data.year_value);
          check_field("month_value", want.month_value, res_if.data.month_value);
          check_field("day_of_month", want.day_of_month, res_if.data.day_of_month);
          check_field("day_of_week", want.day_of_week, res_if.data.day_of_week);
          check_field("hour_value", want.hour_value, res_if.data.hour_value);
          check_field("minute_value", want.minute_value, res_if.data.minute_value);
          check_field("parity_errors", want.parity_errors, res_if.data.parity_errors);
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    msf_pkg::msf_cfg_t c;
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = msf_pkg::REG_MINUTE_MASK;
    cfg_wdata = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // All-zero registers: every decision is both markers, minute wins and
    // decodes the empty stores. Majority at all high, exactly half, and one short.
    program_regs('0);
    push_pattern(8'hFF);
    push_pattern(8'h0F);
    push_pattern(8'h70);

    // Real second markers carrying A and B bits.
    program_regs(FRAME_CFG);
    push_minute();
    repeat (2) push_second(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    push_minute();

    // Full frames with one second per decision.
    program_regs(DENSE_CFG);
    push_dense_minute();
    push_dense_frame(1'b1);
    push_dense_frame(1'b0);

    repeat (2) begin
      c.minute_mask    = DATA_W'($urandom & $urandom & $urandom);
      c.minute_pattern = ($urandom_range(0, 4) == 0) ? DATA_W'($urandom)
                                                      : DATA_W'($urandom) & c.minute_mask;
      c.second_mask    = DATA_W'($urandom & $urandom & $urandom);
      c.second_pattern = DATA_W'($urandom) & c.second_mask;
      program_regs(c);
      run_runs(10);
    end
    program_regs(NO_MINUTE_CFG);
    run_runs(6);

    wait_drain();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== msf_time_code_receiver_top.f =====
rtl/core/msf_pkg.sv
rtl/core/msf_stream_if.sv
rtl/core/msf_rx_core.sv
rtl/core/msf_decode.sv
rtl/core/msf_time_code_receiver_top.sv
dv/msf_time_code_receiver_top_tb.sv
